// File: rtl/pixel_block_ascii_mapper_top_macros.svh
// Assertion macros shared by the pixel block ASCII mapper checkers.
`ifndef PIXEL_BLOCK_ASCII_MAPPER_TOP_MACROS_SVH
`define PIXEL_BLOCK_ASCII_MAPPER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBAM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbam assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PBAM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbam assertion failed");

`endif

// File: rtl/pbam_pkg.sv
// Package of the pixel block ASCII mapper: payload types, codes and constants.
package pbam_pkg;

    localparam int COL_W     = 11;
    localparam int ROW_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 12;
    localparam int SUM_W     = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [COL_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [ROW_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    // Gray = (r+g+b)/3 through an exact reciprocal for sums below 1024.
    localparam int GRAY_SUM_W  = 10;
    localparam int GRAY_SHIFT  = 12;
    localparam int GRAY_RECIP  = 1366;
    localparam int GRAY_PROD_W = 21;

    // Glyph index = avg*27/255, limited to the last table entry.
    localparam int GLYPH_COUNT = 28;
    localparam int IDX_SCALE   = GLYPH_COUNT - 1;
    localparam int GRAY_MAX    = 255;
    localparam int IDX_W       = 5;
    localparam int AVG_W       = 9;
    localparam int AVG_CLAMP   = (GLYPH_COUNT * GRAY_MAX + IDX_SCALE - 1) / IDX_SCALE;
    localparam int IDX_SHIFT   = 17;
    localparam int IDX_RECIP   = (IDX_SCALE * (1 << IDX_SHIFT) + GRAY_MAX - 1) / GRAY_MAX;
    localparam int IDX_RECIP_W = 14;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;
    localparam int CRED_W    = $clog2(OUT_DEPTH + 1);

    localparam logic [7:0] GLYPH_TABLE [GLYPH_COUNT] = '{
        "@", "#", "W", "$", "9", "8", "7", "6", "5", "4",
        "3", "2", "1", "0", "?", "!", "a", "b", "c", ";",
        ":", "+", "=", "-", ",", ".", "_", " "
    };

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } pixel_t;

    typedef struct packed {
        logic [7:0] glyph;
        logic       row_end;
    } result_t;

    // One classified pixel that lies inside a tile that is kept.
    typedef struct packed {
        logic [7:0]       gray;
        logic [COL_W-1:0] tile_col;
        logic             tile_start;
        logic             tile_end;
        logic             row_end;
    } work_t;

endpackage

// File: rtl/pbam_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pbam_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents on a same-address write.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/pbam_fifo.sv
// Small register FIFO with the head shown combinationally.
module pbam_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: rtl/pbam_front.sv
// Front end: frame registers, raster counters, gray conversion and tile classification.
module pbam_front #(
    parameter int BLOCK          = 6,
    parameter int MAX_BLOCK_COLS = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [pbam_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pbam_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               accept,
    input  pbam_pkg::pixel_t                   pixel,
    output logic                               work_push,
    output pbam_pkg::work_t                    work
);

    localparam int COL_W = pbam_pkg::COL_W;
    localparam int ROW_W = pbam_pkg::ROW_W;
    localparam int CX_W  = $clog2(BLOCK);

    logic [COL_W-1:0] frame_width_reg;
    logic [ROW_W-1:0] frame_height_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [CX_W-1:0]  cx_reg, cx_next;
    logic [COL_W-1:0] tcol_reg, tcol_next;
    logic [COL_W-1:0] cbase_reg, cbase_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CX_W-1:0]  ry_reg, ry_next;
    logic [ROW_W-1:0] rbase_reg, rbase_next;

    logic [COL_W-1:0] cur_col, cur_tcol, cur_cbase, w_eff;
    logic [CX_W-1:0]  cur_cx, cur_ry;
    logic [ROW_W-1:0] cur_row, cur_rbase, h_eff;
    logic             col_wrap, row_wrap, col_ok, row_ok, last_tile;

    logic [pbam_pkg::GRAY_SUM_W-1:0]  gray_sum;
    logic [pbam_pkg::GRAY_PROD_W-1:0] gray_prod;

    assign gray_sum = pbam_pkg::GRAY_SUM_W'(pixel.red) + pbam_pkg::GRAY_SUM_W'(pixel.green)
                    + pbam_pkg::GRAY_SUM_W'(pixel.blue);
    assign gray_prod = pbam_pkg::GRAY_PROD_W'(gray_sum)
                     * pbam_pkg::GRAY_PROD_W'(pbam_pkg::GRAY_RECIP);

    always_comb
    begin
        // Frame start restarts the counters before this pixel is placed.
        cur_col   = pixel.frame_start ? '0 : col_reg;
        cur_cx    = pixel.frame_start ? '0 : cx_reg;
        cur_tcol  = pixel.frame_start ? '0 : tcol_reg;
        cur_cbase = pixel.frame_start ? '0 : cbase_reg;
        cur_row   = pixel.frame_start ? '0 : row_reg;
        cur_ry    = pixel.frame_start ? '0 : ry_reg;
        cur_rbase = pixel.frame_start ? '0 : rbase_reg;

        w_eff = (frame_width_reg == '0) ? COL_W'(1) : frame_width_reg;
        h_eff = (frame_height_reg == '0) ? ROW_W'(1) : frame_height_reg;

        col_wrap = ((COL_W + 1)'(cur_col) + (COL_W + 1)'(1)) >= (COL_W + 1)'(w_eff);
        row_wrap = ((ROW_W + 1)'(cur_row) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(h_eff);

        col_ok = ((COL_W + 1)'(cur_cbase) + (COL_W + 1)'(BLOCK) <= (COL_W + 1)'(w_eff))
              && ((COL_W + 1)'(cur_tcol) < (COL_W + 1)'(MAX_BLOCK_COLS));
        row_ok = (ROW_W + 1)'(cur_rbase) + (ROW_W + 1)'(BLOCK) <= (ROW_W + 1)'(h_eff);

        last_tile = ((COL_W + 1)'(cur_tcol) + (COL_W + 1)'(1)
                        == (COL_W + 1)'(MAX_BLOCK_COLS))
                 || ((COL_W + 1)'(cur_cbase) + (COL_W + 1)'(2 * BLOCK)
                        > (COL_W + 1)'(w_eff));

        col_next   = col_reg;
        cx_next    = cx_reg;
        tcol_next  = tcol_reg;
        cbase_next = cbase_reg;
        row_next   = row_reg;
        ry_next    = ry_reg;
        rbase_next = rbase_reg;

        if (accept)
        begin
            row_next   = cur_row;
            ry_next    = cur_ry;
            rbase_next = cur_rbase;
            if (col_wrap)
            begin
                col_next   = '0;
                cx_next    = '0;
                tcol_next  = '0;
                cbase_next = '0;
                if (row_wrap)
                begin
                    row_next   = '0;
                    ry_next    = '0;
                    rbase_next = '0;
                end
                else
                begin
                    row_next = cur_row + 1'b1;
                    if (cur_ry == CX_W'(BLOCK - 1))
                    begin
                        ry_next    = '0;
                        rbase_next = cur_rbase + ROW_W'(BLOCK);
                    end
                    else
                    begin
                        ry_next = cur_ry + 1'b1;
                    end
                end
            end
            else
            begin
                col_next   = cur_col + 1'b1;
                tcol_next  = cur_tcol;
                cbase_next = cur_cbase;
                if (cur_cx == CX_W'(BLOCK - 1))
                begin
                    cx_next    = '0;
                    tcol_next  = cur_tcol + 1'b1;
                    cbase_next = cur_cbase + COL_W'(BLOCK);
                end
                else
                begin
                    cx_next = cur_cx + 1'b1;
                end
            end
        end
    end

    // Drop pixels of partial or excess tiles here; only kept pixels go on.
    assign work_push       = accept && col_ok && row_ok;
    assign work.gray       = gray_prod[pbam_pkg::GRAY_SHIFT +: 8];
    assign work.tile_col   = cur_tcol;
    assign work.tile_start = (cur_cx == '0) && (cur_ry == '0);
    assign work.tile_end   = (cur_cx == CX_W'(BLOCK - 1)) && (cur_ry == CX_W'(BLOCK - 1));
    assign work.row_end    = last_tile;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= pbam_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= pbam_pkg::FRAME_HEIGHT_RESET;
            col_reg          <= '0;
            cx_reg           <= '0;
            tcol_reg         <= '0;
            cbase_reg        <= '0;
            row_reg          <= '0;
            ry_reg           <= '0;
            rbase_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    pbam_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[COL_W-1:0];
                    pbam_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
            col_reg   <= col_next;
            cx_reg    <= cx_next;
            tcol_reg  <= tcol_next;
            cbase_reg <= cbase_next;
            row_reg   <= row_next;
            ry_reg    <= ry_next;
            rbase_reg <= rbase_next;
        end
    end

endmodule

// File: rtl/pbam_back.sv
// Back end: tile accumulator memory, average and glyph pipeline, result credits.
module pbam_back #(
    parameter int BLOCK          = 6,
    parameter int MAX_BLOCK_COLS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pbam_pkg::work_t   work,
    input  logic              work_empty,
    output logic              work_pop,
    output logic              out_push,
    output pbam_pkg::result_t out_item,
    input  logic              result_taken
);

    localparam int SUM_W  = pbam_pkg::SUM_W;
    localparam int ADDR_W = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;
    localparam int DIV    = BLOCK * BLOCK;
    localparam int S1     = SUM_W + $clog2(DIV);
    localparam int R1     = ((1 << S1) + DIV - 1) / DIV;
    localparam int R1_W   = SUM_W + 1;
    localparam int P1_W   = SUM_W + R1_W;
    localparam int AVG_W  = pbam_pkg::AVG_W;
    localparam int P2_W   = AVG_W + pbam_pkg::IDX_RECIP_W;
    localparam int IR_W   = P2_W - pbam_pkg::IDX_SHIFT;
    localparam int IDX_W  = pbam_pkg::IDX_W;
    localparam int CRED_W = pbam_pkg::CRED_W;

    logic [CRED_W-1:0] credit_reg, credit_next;
    logic              take_credit;

    logic [ADDR_W-1:0] rd_addr;
    logic [SUM_W-1:0]  ram_rdata;

    logic              a_valid_reg;
    logic [7:0]        a_gray_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic              a_start_reg, a_end_reg, a_row_end_reg;
    logic              fwd_hit_reg;
    logic [SUM_W-1:0]  fwd_data_reg;
    logic [SUM_W-1:0]  a_old, a_sum;

    logic              g0_valid_reg, g0_row_end_reg;
    logic [SUM_W-1:0]  g0_sum_reg;
    logic              g1_valid_reg, g1_row_end_reg;
    logic [P1_W-1:0]   g1_prod_reg;
    logic              g2_valid_reg, g2_row_end_reg;
    logic [P2_W-1:0]   g2_prod_reg;

    logic [P1_W-S1-1:0] avg;
    logic [AVG_W-1:0]   avg_clamped;
    logic [IR_W-1:0]    idx_raw;
    logic [IDX_W-1:0]   idx;

    // Hold a tile end in the queue until the result FIFO has a slot reserved.
    assign work_pop    = !work_empty && (!work.tile_end || (credit_reg != '0));
    assign take_credit = work_pop && work.tile_end;
    assign rd_addr     = work.tile_col[ADDR_W-1:0];

    always_comb
    begin
        credit_next = credit_reg;
        if (take_credit && !result_taken)
        begin
            credit_next = credit_reg - 1'b1;
        end
        else if (result_taken && !take_credit)
        begin
            credit_next = credit_reg + 1'b1;
        end
    end

    pbam_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_BLOCK_COLS)
    ) u_tile_sums (
        .clk   (clk),
        .we    (a_valid_reg),
        .waddr (a_addr_reg),
        .wdata (a_sum),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Forward the write that landed in the same cycle as this item's read.
    assign a_old = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign a_sum = a_start_reg ? SUM_W'(a_gray_reg) : a_old + SUM_W'(a_gray_reg);

    assign avg         = g1_prod_reg[P1_W-1:S1];
    assign avg_clamped = (avg > (P1_W - S1)'(pbam_pkg::AVG_CLAMP))
                       ? AVG_W'(pbam_pkg::AVG_CLAMP) : avg[AVG_W-1:0];

    assign idx_raw  = g2_prod_reg[P2_W-1:pbam_pkg::IDX_SHIFT];
    assign idx      = (idx_raw > IR_W'(pbam_pkg::IDX_SCALE))
                    ? IDX_W'(pbam_pkg::IDX_SCALE) : idx_raw[IDX_W-1:0];

    assign out_push         = g2_valid_reg;
    assign out_item.glyph   = pbam_pkg::GLYPH_TABLE[idx];
    assign out_item.row_end = g2_row_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg   <= CRED_W'(pbam_pkg::OUT_DEPTH);
            a_valid_reg  <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            g0_valid_reg <= 1'b0;
            g1_valid_reg <= 1'b0;
            g2_valid_reg <= 1'b0;
        end
        else
        begin
            credit_reg   <= credit_next;
            a_valid_reg  <= work_pop;
            fwd_hit_reg  <= a_valid_reg && (a_addr_reg == rd_addr);
            g0_valid_reg <= a_valid_reg && a_end_reg;
            g1_valid_reg <= g0_valid_reg;
            g2_valid_reg <= g1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_gray_reg     <= work.gray;
        a_addr_reg     <= rd_addr;
        a_start_reg    <= work.tile_start;
        a_end_reg      <= work.tile_end;
        a_row_end_reg  <= work.row_end;
        fwd_data_reg   <= a_sum;
        g0_sum_reg     <= a_sum;
        g0_row_end_reg <= a_row_end_reg;
        g1_prod_reg    <= P1_W'(g0_sum_reg) * P1_W'(R1);
        g1_row_end_reg <= g0_row_end_reg;
        g2_prod_reg    <= P2_W'(avg_clamped) * P2_W'(pbam_pkg::IDX_RECIP);
        g2_row_end_reg <= g1_row_end_reg;
    end

endmodule

// File: rtl/pixel_block_ascii_mapper_top.sv
// Top level of the pixel block ASCII mapper: front end, work queue, back end, result FIFO.
//
// Usage:
//   Pixels arrive in raster order on the input queue port: a request is taken
//   at a rising edge with push high and full low. Set frame_start on the first
//   pixel of a frame. Each finished BLOCK x BLOCK tile yields one ASCII glyph
//   on the result port; row_end marks the last tile of a block row. Pixels of
//   partial tiles at the right or bottom edge produce nothing.
//   Results are read as from a queue: result is valid while empty is low and
//   is taken at an edge with pop high.
//   Configuration: frame_width (index 0) and frame_height (index 1) are written
//   through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high.
//   Write them only while no pixel is in flight.
// Throughput: one pixel per clock while full is low; the accumulator read-modify-write
//   forwards its own write, so pixels of the same tile follow back to back.
// Path: a glyph reaches the result port once its tile's last pixel has passed the work
//   queue, the accumulate stage, the g0, g1 and g2 registers and the result FIFO.
// Stall: a stalled reader holds the result FIFO (8 entries); tile ends wait in
//   the 4-entry work queue until a slot is free, and full rises once it fills.
// Reset: counters and the frame size registers (640 x 480) reset; the tile
//   accumulators are not cleared and are written at each tile's first pixel.
module pixel_block_ascii_mapper_top #(
    parameter int BLOCK          = 6,
    parameter int MAX_BLOCK_COLS = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  pbam_pkg::pixel_t                pixel,
    input  logic                            pop,
    output logic                            empty,
    output pbam_pkg::result_t               result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pbam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pbam_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic              accept;
    logic              work_push, work_full, work_pop, work_empty;
    pbam_pkg::work_t   work_in, work_head;
    logic              out_push;
    pbam_pkg::result_t out_item;
    logic              result_taken;

    // Take configuration writes at any time; the front end applies them at once.
    assign cfg_ready    = 1'b1;
    // Accept a pixel whenever the work queue has room, kept or dropped alike.
    assign full         = work_full;
    assign accept       = push && !work_full;
    assign result_taken = pop && !empty;

    pbam_front #(
        .BLOCK          (BLOCK),
        .MAX_BLOCK_COLS (MAX_BLOCK_COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pixel     (pixel),
        .work_push (work_push),
        .work      (work_in)
    );

    // Decouple classification from accumulation.
    pbam_fifo #(
        .WIDTH ($bits(pbam_pkg::work_t)),
        .DEPTH (pbam_pkg::MID_DEPTH)
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (work_push),
        .wdata (work_in),
        .full  (work_full),
        .pop   (work_pop),
        .rdata (work_head),
        .empty (work_empty)
    );

    pbam_back #(
        .BLOCK          (BLOCK),
        .MAX_BLOCK_COLS (MAX_BLOCK_COLS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .work         (work_head),
        .work_empty   (work_empty),
        .work_pop     (work_pop),
        .out_push     (out_push),
        .out_item     (out_item),
        .result_taken (result_taken)
    );

    // Never overflows: the back end reserves a slot before each glyph.
    pbam_fifo #(
        .WIDTH ($bits(pbam_pkg::result_t)),
        .DEPTH (pbam_pkg::OUT_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_item),
        .full  (),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

// File: rtl/pbam_checker.sv
// Port-level checker for the pixel block ASCII mapper, bound to the top level.
`include "pixel_block_ascii_mapper_top_macros.svh"

module pbam_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input logic              pop,
    input logic              empty,
    input pbam_pkg::result_t result
);

    // A waiting result stays until it is popped.
    `PBAM_ASSERT_NEXT(a_result_held, !empty && !pop, !empty)
    `PBAM_ASSERT_NEXT(a_result_stable, !empty && !pop, $stable(result))
    // The work queue fills only through an accepted pixel request.
    `PBAM_ASSERT_SAME(a_full_after_push, $rose(full), $past(push && !full))
    // The result queue drains only through a pop.
    `PBAM_ASSERT_SAME(a_empty_after_pop, $rose(empty), $past(pop))

endmodule

bind pixel_block_ascii_mapper_top pbam_checker u_pbam_checker (.*);

// File: tb/pixel_block_ascii_mapper_top_tb.sv
// Self-checking testbench for the pixel block ASCII mapper top level.
module pixel_block_ascii_mapper_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK_SIZE    = 6;
    localparam int MAX_COLS      = 256;
    localparam int TILE_PIXELS   = BLOCK_SIZE * BLOCK_SIZE;
    localparam int GRAY_FULL     = 255;
    localparam int LAST_GLYPH    = 27;
    localparam int IDLE_PCT      = 32;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 800;
    localparam int STALL_TILES   = 16;
    localparam int STALL_CYCLES  = 1500;
    localparam int CYCLE_LIMIT   = 1000000;

    // Character ramp from darkest to brightest; entry 0 sits in the top byte.
    localparam bit [8*(LAST_GLYPH+1)-1:0] GLYPH_CHARS = "@#W$9876543210?!abc;:+=-,._ ";

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            push      = 1'b0;
    logic                            full;
    pbam_pkg::pixel_t                pixel     = '0;
    logic                            pop       = 1'b0;
    logic                            empty;
    pbam_pkg::result_t               result;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [pbam_pkg::CFG_IDX_W-1:0]  cfg_index = pbam_pkg::CFG_FRAME_WIDTH;
    logic [pbam_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state: frame size registers, raster position and tile sums.
    logic [pbam_pkg::COL_W-1:0] frame_width_reg  = pbam_pkg::FRAME_WIDTH_RESET;
    logic [pbam_pkg::ROW_W-1:0] frame_height_reg = pbam_pkg::FRAME_HEIGHT_RESET;
    int                         col_pos          = 0;
    int                         row_pos          = 0;
    int                         tile_sum [MAX_COLS];

    pbam_pkg::result_t pending_glyphs [$];
    int                mismatches     = 0;
    int                items_sent     = 0;
    int                cycle_count    = 0;
    int                send_idle_pct  = IDLE_PCT;
    int                recv_idle_pct  = IDLE_PCT;
    int                reader_hold    = 0;
    bit                restart_due    = 1'b1;
    int                tile_level [16];

    pixel_block_ascii_mapper_top #(
        .BLOCK          (BLOCK_SIZE),
        .MAX_BLOCK_COLS (MAX_COLS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run: report failure once the cycle budget is spent.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Advance the predictor by one accepted pixel; queue a glyph when a tile closes.
    function automatic void track_pixel(input pbam_pkg::pixel_t p);
        int                w;
        int                h;
        int                gray;
        int                used_cols;
        int                bc;
        int                avg;
        int                idx;
        pbam_pkg::result_t r;
        w = (frame_width_reg == 0) ? 1 : int'(frame_width_reg);
        h = (frame_height_reg == 0) ? 1 : int'(frame_height_reg);
        gray = (int'(p.red) + int'(p.green) + int'(p.blue)) / 3;
        used_cols = (w / BLOCK_SIZE < MAX_COLS) ? w / BLOCK_SIZE : MAX_COLS;
        if (p.frame_start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        bc = col_pos / BLOCK_SIZE;
        // Pixels of partial tiles and of block columns past the limit drop out here.
        if (bc < used_cols && row_pos / BLOCK_SIZE < h / BLOCK_SIZE)
        begin
            // The first pixel of a tile overwrites the sum; the rest add to it.
            if (col_pos % BLOCK_SIZE == 0 && row_pos % BLOCK_SIZE == 0)
                tile_sum[bc] = gray;
            else
                tile_sum[bc] = tile_sum[bc] + gray;
            if (col_pos % BLOCK_SIZE == BLOCK_SIZE - 1 && row_pos % BLOCK_SIZE == BLOCK_SIZE - 1)
            begin
                avg = tile_sum[bc] / TILE_PIXELS;
                idx = avg * LAST_GLYPH / GRAY_FULL;
                if (idx > LAST_GLYPH)
                    idx = LAST_GLYPH;
                r.glyph   = GLYPH_CHARS[8*(LAST_GLYPH-idx) +: 8];
                r.row_end = (bc + 1 == used_cols);
                pending_glyphs.push_back(r);
            end
        end
        // Wrap the column at the line end and the row at the frame end; a position
        // already past a lowered register counts as the last one too.
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
    endfunction

    function automatic logic [7:0] near_level(input int lvl);
        int v;
        v = lvl + int'($urandom_range(0, 30)) - 15;
        if (v < 0)
            v = 0;
        if (v > GRAY_FULL)
            v = GRAY_FULL;
        return v[7:0];
    endfunction

    // Build a pixel whose brightness follows its block column, so tile averages spread
    // over the whole ramp; a few pixels carry fully random channels.
    function automatic pbam_pkg::pixel_t shaped_pixel();
        pbam_pkg::pixel_t p;
        int               lvl;
        lvl = tile_level[(col_pos / BLOCK_SIZE) % 16];
        if ($urandom_range(0, 7) == 0)
        begin
            p.red   = 8'($urandom_range(0, GRAY_FULL));
            p.green = 8'($urandom_range(0, GRAY_FULL));
            p.blue  = 8'($urandom_range(0, GRAY_FULL));
        end
        else
        begin
            p.red   = near_level(lvl);
            p.green = near_level(lvl);
            p.blue  = near_level(lvl);
        end
        p.frame_start = 1'b0;
        return p;
    endfunction

    function automatic void pick_levels();
        for (int i = 0; i < 16; i++)
        begin
            case ($urandom_range(0, 5))
                0:       tile_level[i] = 0;
                1:       tile_level[i] = GRAY_FULL;
                default: tile_level[i] = int'($urandom_range(0, GRAY_FULL));
            endcase
        end
    endfunction

    // Offer one pixel request and hold it until the block takes it. Enter and leave
    // at a falling edge; push stays high on return so back-to-back requests never
    // drop it in between.
    task automatic send_pixel(input pbam_pkg::pixel_t p);
        bit taken;
        // Force a frame start after every size change so no tile reads a stale sum.
        if (restart_due)
            p.frame_start = 1'b1;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
            @(negedge clk);
        end
        push  <= 1'b1;
        pixel <= p;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            if (!full)
            begin
                taken = 1'b1;
                track_pixel(p);
                restart_due = 1'b0;
                items_sent++;
            end
            @(negedge clk);
        end
    endtask

    task automatic send_fill(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input int count);
        pbam_pkg::pixel_t p;
        for (int k = 0; k < count; k++)
        begin
            p = '{red: r, green: g, blue: b, frame_start: (k == 0)};
            send_pixel(p);
        end
    endtask

    // Send a raster run; when noisy, scatter a rare early frame start inside it.
    task automatic send_frame(input int count, input bit noisy);
        pbam_pkg::pixel_t p;
        pick_levels();
        for (int k = 0; k < count; k++)
        begin
            p = shaped_pixel();
            p.frame_start = (k == 0);
            if (noisy && $urandom_range(0, 199) == 0)
                p.frame_start = 1'b1;
            send_pixel(p);
        end
    endtask

    // Continue the current frame with no frame start at all.
    task automatic send_run(input int count);
        for (int k = 0; k < count; k++)
            send_pixel(shaped_pixel());
    endtask

    // Drop push, wait for every expected glyph, then let pixels that make no glyph
    // clear the pipeline before anything is reconfigured.
    task automatic drain_results();
        push <= 1'b0;
        while (pending_glyphs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Hold a register write request until the block takes it; valid stays high.
    task automatic write_reg(input logic [pbam_pkg::CFG_IDX_W-1:0] idx, input int value);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[pbam_pkg::CFG_DATA_W-1:0];
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            if (cfg_ready)
            begin
                taken = 1'b1;
                if (idx == pbam_pkg::CFG_FRAME_WIDTH)
                    frame_width_reg = value[pbam_pkg::COL_W-1:0];
                else
                    frame_height_reg = value[pbam_pkg::ROW_W-1:0];
            end
            @(negedge clk);
        end
    endtask

    task automatic set_frame(input int w, input int h);
        drain_results();
        write_reg(pbam_pkg::CFG_FRAME_WIDTH, w);
        write_reg(pbam_pkg::CFG_FRAME_HEIGHT, h);
        cfg_valid   <= 1'b0;
        restart_due  = 1'b1;
    endtask

    // Darkest and brightest tiles, each channel alone at full scale, the gray value
    // just below full, and a frame start that cuts a tile short.
    task automatic test_tile_extremes();
        pbam_pkg::pixel_t p;
        set_frame(BLOCK_SIZE, BLOCK_SIZE);
        send_fill(8'd0, 8'd0, 8'd0, TILE_PIXELS);
        send_fill(8'd255, 8'd255, 8'd255, TILE_PIXELS);
        for (int k = 0; k < TILE_PIXELS; k++)
        begin
            p = '0;
            case (k % 3)
                0:       p.red   = 8'd255;
                1:       p.green = 8'd255;
                default: p.blue  = 8'd255;
            endcase
            p.frame_start = (k == 0);
            send_pixel(p);
        end
        send_fill(8'd255, 8'd255, 8'd254, TILE_PIXELS);
        send_fill(8'd128, 8'd64, 8'd32, 10);
        send_fill(8'd200, 8'd10, 8'd90, TILE_PIXELS);
    endtask

    // Partial tiles at the right and bottom edges, wrap to the top without a frame
    // start, sizes too small for any tile, and zero-size registers.
    task automatic test_edges_and_wrap();
        set_frame(13, 13);
        send_frame(13 * 13, 1'b0);
        send_run(13 * BLOCK_SIZE);
        set_frame(BLOCK_SIZE, BLOCK_SIZE + 1);
        send_frame(BLOCK_SIZE * (BLOCK_SIZE + 1) * 2, 1'b0);
        set_frame(0, 0);
        send_frame(5, 1'b0);
        set_frame(BLOCK_SIZE - 1, 12);
        send_frame(60, 1'b0);
        set_frame(12, 0);
        send_frame(24, 1'b0);
    endtask

    // Tallest frame and a width write with the unused top data bit set.
    task automatic test_size_limits();
        set_frame(BLOCK_SIZE, 4095);
        send_frame(2 * TILE_PIXELS, 1'b0);
        set_frame('h800 | BLOCK_SIZE, BLOCK_SIZE);
        send_frame(TILE_PIXELS, 1'b0);
    endtask

    // Hold the reader off for a long stretch while pixels stream in without gaps,
    // so the result FIFO and work queue fill and full pushes back on the sender.
    task automatic test_full_stall();
        set_frame(BLOCK_SIZE, BLOCK_SIZE);
        send_idle_pct = 0;
        @(posedge clk);
        reader_hold = STALL_CYCLES;
        @(negedge clk);
        send_frame(STALL_TILES * TILE_PIXELS, 1'b0);
        send_idle_pct = IDLE_PCT;
    endtask

    // Mostly well-formed frames of random small sizes, some cut short, some with a
    // stray frame start; the first phase runs with no idling on either side.
    task automatic test_random_frames();
        int phase;
        int w;
        int h;
        int target;
        phase  = 0;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 7);
                1:       w = BLOCK_SIZE * $urandom_range(1, 8);
                default: w = $urandom_range(BLOCK_SIZE, 48);
            endcase
            if ($urandom_range(0, 9) == 0)
                h = $urandom_range(0, 7);
            else
                h = $urandom_range(BLOCK_SIZE, 18);
            set_frame(w, h);
            send_idle_pct = (phase == 0) ? 0 : IDLE_PCT;
            recv_idle_pct = (phase == 0) ? 0 : IDLE_PCT;
            repeat ($urandom_range(1, 2))
            begin
                if ($urandom_range(0, 5) == 0)
                    send_frame($urandom_range(1, w * h + 1), 1'b1);
                else
                    send_frame((w == 0 ? 1 : w) * (h == 0 ? 1 : h), 1'b1);
            end
            phase++;
        end
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
    endtask

    // Reader: pick pop at each falling edge; a requested hold-off is counted here.
    initial
    begin : result_reader
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (reader_hold != 0)
            begin
                hold_left   = reader_hold;
                reader_hold = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Checker: compare every taken result with the oldest expected glyph.
    always @(posedge clk)
    begin
        pbam_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_glyphs.size() == 0)
            begin
                mismatches++;
                $display("%t: result with none expected: glyph %h row_end %b",
                         $time, result.glyph, result.row_end);
            end
            else
            begin
                want = pending_glyphs.pop_front();
                if (result.glyph !== want.glyph)
                begin
                    mismatches++;
                    $display("%t: glyph expected %h actual %h",
                             $time, want.glyph, result.glyph);
                end
                if (result.row_end !== want.row_end)
                begin
                    mismatches++;
                    $display("%t: row_end expected %b actual %b",
                             $time, want.row_end, result.row_end);
                end
            end
        end
    end

    // Main sequence: reset once, run each test, then wait out the pipeline.
    initial
    begin
        for (int i = 0; i < MAX_COLS; i++)
            tile_sum[i] = 0;
        pick_levels();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_tile_extremes();
        test_edges_and_wrap();
        test_size_limits();
        test_full_stall();
        test_random_frames();

        drain_results();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: pixel_block_ascii_mapper_top.f
+incdir+rtl
rtl/pbam_pkg.sv
rtl/pbam_ram.sv
rtl/pbam_fifo.sv
rtl/pbam_front.sv
rtl/pbam_back.sv
rtl/pixel_block_ascii_mapper_top.sv
rtl/pbam_checker.sv
tb/pixel_block_ascii_mapper_top_tb.sv
